[sv/uf_pkg.sv]
// ----------------------------------------------------------------------------
// uf_pkg
// shared types, field widths, operation codes and helpers of the disjoint-set engine
// ----------------------------------------------------------------------------
package uf_pkg;

    localparam int unsigned ITEM_W           = 10;
    localparam int unsigned COUNT_W          = 11;
    localparam int unsigned DEF_MAX_ELEMENTS = 1024;
    localparam int unsigned RESET_COUNT      = 1024;

    localparam logic [1:0] ACT_FIND  = 2'd0;
    localparam logic [1:0] ACT_MERGE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK,
        ST_COMP_RD,
        ST_COMP,
        ST_DONE
    } t_uf_state;

    typedef struct packed {
        logic [1:0]        action;
        logic [ITEM_W-1:0] first_item;
        logic [ITEM_W-1:0] second_item;
    } t_uf_req;

    typedef struct packed {
        logic [ITEM_W-1:0]  root_found;
        logic               same_set;
        logic [COUNT_W-1:0] set_total;
        logic               index_error;
    } t_uf_rsp;

    // element count limited to 1 .. max
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input int unsigned maxv);
        logic [COUNT_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = COUNT_W'(1);
        end else if (32'(v) > maxv) begin
            res = COUNT_W'(maxv);
        end
        return res;
    endfunction

endpackage

[sv/uf_ram.sv]
// ----------------------------------------------------------------------------
// uf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module uf_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/uf_seq.sv]
// ----------------------------------------------------------------------------
// uf_seq
// sequencer: table clearing sweep, root walk, path compression and linking
// ----------------------------------------------------------------------------
module uf_seq #(
    parameter int unsigned MAX_ELEMENTS = uf_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic [uf_pkg::COUNT_W-1:0] i_new_count,
    input  logic [uf_pkg::COUNT_W-1:0] i_count,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  uf_pkg::t_uf_req            i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output uf_pkg::t_uf_rsp            o_rsp
);

    localparam int unsigned AW   = $clog2(MAX_ELEMENTS);
    localparam int unsigned IW   = uf_pkg::ITEM_W;
    localparam int unsigned CW   = uf_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST = AW'(MAX_ELEMENTS - 1);

    uf_pkg::t_uf_state r_state, n_state;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_root, n_root;
    logic [AW-1:0] r_root_a, n_root_a;
    logic [AW-1:0] r_idx_a, n_idx_a;
    logic [AW-1:0] r_idx_b, n_idx_b;
    logic          r_second, n_second;
    logic [1:0]    r_act, n_act;
    logic [IW-1:0] r_res_root, n_res_root;
    logic          r_res_same, n_res_same;
    logic          r_res_err, n_res_err;
    logic [CW-1:0] r_sets, n_sets;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [AW-1:0] ram_rdata;

    logic          a_bad;
    logic          b_bad;
    logic          roots_same;
    logic [AW-1:0] root_min;
    logic [AW-1:0] root_max;

    uf_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ELEMENTS)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign a_bad      = {1'b0, i_req.first_item} >= i_count;
    assign b_bad      = {1'b0, i_req.second_item} >= i_count;
    assign roots_same = r_root_a == r_root;
    assign root_min   = (r_root_a < r_root) ? r_root_a : r_root;
    assign root_max   = (r_root_a < r_root) ? r_root : r_root_a;

    // next state
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_root     = r_root;
        n_root_a   = r_root_a;
        n_idx_a    = r_idx_a;
        n_idx_b    = r_idx_b;
        n_second   = r_second;
        n_act      = r_act;
        n_res_root = r_res_root;
        n_res_same = r_res_same;
        n_res_err  = r_res_err;
        n_sets     = r_sets;
        case (r_state)
            uf_pkg::ST_SWEEP: begin
                if (r_cur == LAST) begin
                    n_state = uf_pkg::ST_IDLE;
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            uf_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_act      = i_req.action;
                    n_idx_a    = AW'(i_req.first_item);
                    n_idx_b    = AW'(i_req.second_item);
                    n_cur      = AW'(i_req.first_item);
                    n_second   = 1'b0;
                    n_res_root = '0;
                    n_res_same = 1'b0;
                    n_res_err  = 1'b0;
                    case (i_req.action)
                        uf_pkg::ACT_FIND: begin
                            if (a_bad) begin
                                n_res_err = 1'b1;
                                n_state   = uf_pkg::ST_DONE;
                            end else begin
                                n_state = uf_pkg::ST_WALK_RD;
                            end
                        end
                        uf_pkg::ACT_MERGE, uf_pkg::ACT_QUERY: begin
                            if (a_bad || b_bad) begin
                                n_res_err = 1'b1;
                                n_state   = uf_pkg::ST_DONE;
                            end else begin
                                n_state = uf_pkg::ST_WALK_RD;
                            end
                        end
                        default: begin
                            n_state = uf_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            uf_pkg::ST_WALK_RD: begin
                n_state = uf_pkg::ST_WALK;
            end
            uf_pkg::ST_WALK: begin
                if (ram_rdata == r_cur) begin
                    n_root  = r_cur;
                    n_cur   = r_second ? r_idx_b : r_idx_a;
                    n_state = uf_pkg::ST_COMP_RD;
                end else begin
                    n_cur = ram_rdata;
                end
            end
            uf_pkg::ST_COMP_RD: begin
                n_state = uf_pkg::ST_COMP;
            end
            uf_pkg::ST_COMP: begin
                if (r_cur != r_root) begin
                    n_cur = ram_rdata;
                end else if (!r_second) begin
                    if (r_act == uf_pkg::ACT_FIND) begin
                        n_res_root = IW'(r_root);
                        n_state    = uf_pkg::ST_DONE;
                    end else begin
                        n_root_a = r_root;
                        n_second = 1'b1;
                        n_cur    = r_idx_b;
                        n_state  = uf_pkg::ST_WALK_RD;
                    end
                end else begin
                    if (roots_same) begin
                        n_res_same = 1'b1;
                        n_res_root = IW'(r_root_a);
                    end else if (r_act == uf_pkg::ACT_MERGE) begin
                        n_res_root = IW'(root_min);
                        if (r_sets != '0) begin
                            n_sets = r_sets - 1'b1;
                        end
                    end else begin
                        n_res_root = IW'(r_root_a);
                    end
                    n_state = uf_pkg::ST_DONE;
                end
            end
            uf_pkg::ST_DONE: begin
                if (i_rsp_ready) begin
                    n_state = uf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = uf_pkg::ST_IDLE;
            end
        endcase
        if (i_restart) begin
            n_state = uf_pkg::ST_SWEEP;
            n_cur   = '0;
            n_sets  = i_new_count;
        end
    end

    // memory ports and handshake
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_cur;
        ram_wdata   = r_cur;
        ram_raddr   = r_cur;
        o_req_ready = r_state == uf_pkg::ST_IDLE;
        o_rsp_valid = r_state == uf_pkg::ST_DONE;
        case (r_state)
            uf_pkg::ST_SWEEP: begin
                ram_we = 1'b1;
            end
            uf_pkg::ST_WALK: begin
                ram_raddr = ram_rdata;
            end
            uf_pkg::ST_COMP: begin
                if (r_cur != r_root) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_root;
                    ram_raddr = ram_rdata;
                end else if (r_second && !roots_same && r_act == uf_pkg::ACT_MERGE) begin
                    ram_we    = 1'b1;
                    ram_waddr = root_max;
                    ram_wdata = root_min;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uf_pkg::ST_SWEEP;
            r_cur   <= '0;
            r_sets  <= uf_pkg::clamp_count(CW'(uf_pkg::RESET_COUNT), MAX_ELEMENTS);
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_sets  <= n_sets;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root     <= n_root;
        r_root_a   <= n_root_a;
        r_idx_a    <= n_idx_a;
        r_idx_b    <= n_idx_b;
        r_second   <= n_second;
        r_act      <= n_act;
        r_res_root <= n_res_root;
        r_res_same <= n_res_same;
        r_res_err  <= n_res_err;
    end

    assign o_rsp.root_found  = r_res_root;
    assign o_rsp.same_set    = r_res_same;
    assign o_rsp.set_total   = r_sets;
    assign o_rsp.index_error = r_res_err;

endmodule

[sv/union_find_engine.sv]
// ----------------------------------------------------------------------------
// union_find_engine
// disjoint-set engine over a parent table with path compression
// ----------------------------------------------------------------------------
// requests arrive on the slave stream: find, merge or connected query on one
// or two element indexes. each request gives one result on the master stream
// with the root, the same-set flag, the set count and an index error flag.
// i_cfg_we with i_cfg_wdata writes the element count (clamped to 1 ..
// MAX_ELEMENTS) and restarts every element as its own set.
// after reset and after every count write the parent table is cleared by a
// sweep over all MAX_ELEMENTS entries, one entry a cycle, with o_s_tready low.
// one request at a time; the parent memory port sets the pace, one pointer
// per cycle. a find walks the chain from the element up to its root and
// then walks that path again, pointing every entry on it at the root;
// merge and query run two finds back to back and a merge links the larger
// root under the smaller; an out-of-range index or unused action skips the walk.
// the result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver holds the engine once the next is done.
// ----------------------------------------------------------------------------
module union_find_engine #(
    parameter int unsigned MAX_ELEMENTS = uf_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [uf_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [23:0]                i_s_tdata,  // action, first_item, second_item
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [23:0]                o_m_tdata   // root_found, same_set, set_total, index_error
);

    localparam int unsigned CW = uf_pkg::COUNT_W;
    localparam int unsigned IW = uf_pkg::ITEM_W;

    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;
    uf_pkg::t_uf_rsp r_out, n_out;

    uf_pkg::t_uf_req req;
    uf_pkg::t_uf_rsp rsp;
    logic            rsp_valid;
    logic            rsp_ready;

    assign req.action      = i_s_tdata[1:0];
    assign req.first_item  = i_s_tdata[2 +: IW];
    assign req.second_item = i_s_tdata[2 + IW +: IW];

    always_comb begin
        n_count = r_count;
        if (i_cfg_we) begin
            n_count = uf_pkg::clamp_count(i_cfg_wdata, MAX_ELEMENTS);
        end
    end

    assign rsp_ready = !r_out_valid || i_m_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (rsp_valid && rsp_ready) begin
            n_out_valid = 1'b1;
            n_out       = rsp;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    uf_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_new_count (n_count),
        .i_count     (r_count),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= uf_pkg::clamp_count(CW'(uf_pkg::RESET_COUNT), MAX_ELEMENTS);
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.index_error, r_out.set_total,
                         r_out.same_set, r_out.root_found};

endmodule
